// ===== rtl/oas_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered array store package
// Shared types, operation and status codes and sequencer states.
// ----------------------------------------------------------------------------
package oas_pkg;

   localparam int DEPTH_DEFAULT         = 64;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;
   localparam int POS_W                 = 7;
   localparam int CNT_OUT_W             = 7;
   localparam int ELEM_OUT_W            = 32;
   localparam int OP_W                  = 4;
   localparam int STATUS_W              = 2;

   localparam logic [OP_W-1:0] OP_APPEND    = 4'd0;
   localparam logic [OP_W-1:0] OP_PREPEND   = 4'd1;
   localparam logic [OP_W-1:0] OP_INSERT    = 4'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK  = 4'd3;
   localparam logic [OP_W-1:0] OP_POP_FRONT = 4'd4;
   localparam logic [OP_W-1:0] OP_REMOVE    = 4'd5;
   localparam logic [OP_W-1:0] OP_READ      = 4'd6;
   localparam logic [OP_W-1:0] OP_REVERSE   = 4'd7;
   localparam logic [OP_W-1:0] OP_SORT      = 4'd8;
   localparam logic [OP_W-1:0] OP_CLEAR     = 4'd9;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]              operation;
      logic [POS_W-1:0]             position;
      logic signed [ELEM_OUT_W-1:0] new_value;
   } req_item_type;

   typedef struct packed {
      logic signed [ELEM_OUT_W-1:0] element_out;
      logic [CNT_OUT_W-1:0]         element_count;
      logic [STATUS_W-1:0]          status;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT,
      ST_REV_RD_LO,
      ST_REV_RD_HI,
      ST_REV_WR_LO,
      ST_REV_WR_HI,
      ST_SORT_RD0,
      ST_SORT_LOAD,
      ST_SORT_RD,
      ST_SORT_WR,
      ST_SORT_LAST,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/oas_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module oas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/ordered_array_store.sv =====
// Insert and remove move each element behind the position one place, one at a time.
// Reverse swaps pairs of elements from both ends inward.
// Sort: stable exchange passes over the array, up to n passes, all through the one RAM.
// One item at a time: busy is high from acceptance through the one-cycle rsp_valid strobe.
// Synchronous reset empties the array and clears the sort order; element RAM is not cleared.
// ----------------------------------------------------------------------------
// Ordered array store
// Fixed-depth signed element array with count, edited and sorted in place.
// ----------------------------------------------------------------------------
module ordered_array_store #(
   parameter int DEPTH         = oas_pkg::DEPTH_DEFAULT,
   parameter int ELEMENT_WIDTH = oas_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  oas_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output oas_pkg::rsp_item_type rsp_item,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   import oas_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] jdx_ff, jdx_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [ELEMENT_WIDTH-1:0] hold_ff, hold_in;
   logic [ELEMENT_WIDTH-1:0] val_ff, val_in;
   logic [ELEMENT_WIDTH-1:0] elem_ff, elem_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic up_ff, up_in;
   logic is_read_ff, is_read_in;
   logic swapped_ff, swapped_in;
   logic desc_ff;

   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [ELEMENT_WIDTH-1:0] wr_data, rd_data;

   logic [XW-1:0] pos_x, cnt_x, at_x;
   logic [CW-1:0] idx_step;
   logic          shift_more, fetch_more, rev_more, sort_more, swap;
   logic          accept;

   oas_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign accept   = start && (state_ff == ST_IDLE);
   assign pos_x    = XW'(req_item.position);
   assign cnt_x    = XW'(cnt_ff);
   assign idx_step = up_ff ? (idx_ff - CW'(1)) : (idx_ff + CW'(1));
   assign shift_more = up_ff ? (idx_step > lim_ff) : ((idx_step + CW'(1)) < lim_ff);
   assign fetch_more = (idx_ff + CW'(1)) < lim_ff;
   assign rev_more   = (idx_ff + CW'(1)) < (jdx_ff - CW'(1));
   assign sort_more  = (idx_ff + CW'(1)) < cnt_ff;
   assign swap = desc_ff ? ($signed(rd_data) > $signed(hold_ff))
                         : ($signed(rd_data) < $signed(hold_ff));

   always_comb begin
      unique case (req_item.operation)
         OP_APPEND:  at_x = cnt_x;
         OP_PREPEND: at_x = '0;
         default:    at_x = pos_x;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.operation)
                  OP_APPEND, OP_PREPEND, OP_INSERT: begin
                     if (cnt_ff == CW'(DEPTH) || at_x > cnt_x) begin
                        state_in = ST_DONE;
                     end else if (cnt_x > at_x) begin
                        state_in = ST_SHIFT_RD;
                     end else begin
                        state_in = ST_PUT;
                     end
                  end
                  OP_POP_BACK, OP_POP_FRONT: begin
                     state_in = (cnt_ff == '0) ? ST_DONE : ST_FETCH;
                  end
                  OP_REMOVE, OP_READ: begin
                     state_in = (pos_x >= cnt_x) ? ST_DONE : ST_FETCH;
                  end
                  OP_REVERSE: state_in = (cnt_ff < CW'(2)) ? ST_DONE : ST_REV_RD_LO;
                  OP_SORT:    state_in = (cnt_ff < CW'(2)) ? ST_DONE : ST_SORT_RD0;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_FETCH:      state_in = ST_FETCH_WAIT;
         ST_FETCH_WAIT: state_in = (!is_read_ff && fetch_more) ? ST_SHIFT_RD : ST_DONE;
         ST_SHIFT_RD:   state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: begin
            if (shift_more) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = up_ff ? ST_PUT : ST_DONE;
            end
         end
         ST_PUT:       state_in = ST_DONE;
         ST_REV_RD_LO: state_in = ST_REV_RD_HI;
         ST_REV_RD_HI: state_in = ST_REV_WR_LO;
         ST_REV_WR_LO: state_in = ST_REV_WR_HI;
         ST_REV_WR_HI: state_in = rev_more ? ST_REV_RD_LO : ST_DONE;
         ST_SORT_RD0:  state_in = ST_SORT_LOAD;
         ST_SORT_LOAD: state_in = ST_SORT_RD;
         ST_SORT_RD:   state_in = ST_SORT_WR;
         ST_SORT_WR:   state_in = sort_more ? ST_SORT_RD : ST_SORT_LAST;
         ST_SORT_LAST: state_in = swapped_ff ? ST_SORT_RD0 : ST_DONE;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      jdx_in     = jdx_ff;
      lim_in     = lim_ff;
      hold_in    = hold_ff;
      val_in     = val_ff;
      elem_in    = elem_ff;
      status_in  = status_ff;
      up_in      = up_ff;
      is_read_in = is_read_ff;
      swapped_in = swapped_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff[AW-1:0];
      wr_data    = rd_data;
      rd_en      = 1'b0;
      rd_addr    = idx_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               elem_in    = '0;
               status_in  = STATUS_OK;
               is_read_in = 1'b0;
               val_in     = ELEMENT_WIDTH'($unsigned(req_item.new_value));
               unique case (req_item.operation)
                  OP_APPEND, OP_PREPEND, OP_INSERT: begin
                     up_in  = 1'b1;
                     idx_in = cnt_ff;
                     lim_in = CW'(at_x);
                     if (cnt_ff == CW'(DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else if (at_x > cnt_x) begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  OP_POP_BACK, OP_POP_FRONT, OP_REMOVE: begin
                     up_in  = 1'b0;
                     lim_in = cnt_ff;
                     unique case (req_item.operation)
                        OP_POP_BACK:  idx_in = cnt_ff - CW'(1);
                        OP_POP_FRONT: idx_in = '0;
                        default:      idx_in = CW'(pos_x);
                     endcase
                     if (cnt_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else if (req_item.operation == OP_REMOVE && pos_x >= cnt_x) begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  OP_READ: begin
                     is_read_in = 1'b1;
                     idx_in     = CW'(pos_x);
                     if (pos_x >= cnt_x) begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  OP_REVERSE: begin
                     idx_in = '0;
                     jdx_in = cnt_ff - CW'(1);
                  end
                  OP_CLEAR: cnt_in = '0;
                  default: ;
               endcase
            end
         end
         ST_FETCH: rd_en = 1'b1;
         ST_FETCH_WAIT: begin
            elem_in = rd_data;
            if (!is_read_ff) begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_SHIFT_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_step[AW-1:0];
         end
         ST_SHIFT_WR: begin
            wr_en  = 1'b1;
            idx_in = idx_step;
         end
         ST_PUT: begin
            wr_en   = 1'b1;
            wr_addr = lim_ff[AW-1:0];
            wr_data = val_ff;
            cnt_in  = cnt_ff + CW'(1);
         end
         ST_REV_RD_LO: rd_en = 1'b1;
         ST_REV_RD_HI: begin
            rd_en   = 1'b1;
            rd_addr = jdx_ff[AW-1:0];
            hold_in = rd_data;
         end
         ST_REV_WR_LO: wr_en = 1'b1;
         ST_REV_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = jdx_ff[AW-1:0];
            wr_data = hold_ff;
            idx_in  = idx_ff + CW'(1);
            jdx_in  = jdx_ff - CW'(1);
         end
         ST_SORT_RD0: begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            idx_in     = CW'(1);
            swapped_in = 1'b0;
         end
         ST_SORT_LOAD: hold_in = rd_data;
         ST_SORT_RD:   rd_en = 1'b1;
         ST_SORT_WR: begin
            wr_en      = 1'b1;
            wr_addr    = AW'(idx_ff - CW'(1));
            wr_data    = swap ? rd_data : hold_ff;
            hold_in    = swap ? hold_ff : rd_data;
            swapped_in = swapped_ff | swap;
            idx_in     = idx_ff + CW'(1);
         end
         ST_SORT_LAST: begin
            wr_en   = 1'b1;
            wr_addr = AW'(cnt_ff - CW'(1));
            wr_data = hold_ff;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      busy                   = (state_ff != ST_IDLE);
      rsp_valid              = (state_ff == ST_DONE);
      rsp_item.element_out   = ELEM_OUT_W'($signed(elem_ff));
      rsp_item.element_count = CNT_OUT_W'(cnt_ff);
      rsp_item.status        = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         desc_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_write_enable) begin
            desc_ff <= csr_write_data;
         end
      end
      idx_ff     <= idx_in;
      jdx_ff     <= jdx_in;
      lim_ff     <= lim_in;
      hold_ff    <= hold_in;
      val_ff     <= val_in;
      elem_ff    <= elem_in;
      status_ff  <= status_in;
      up_ff      <= up_in;
      is_read_ff <= is_read_in;
      swapped_ff <= swapped_in;
   end

endmodule

// ===== rtl/oas_checker.sv =====
// ----------------------------------------------------------------------------
// Ordered array store checker
// Port-level checks of the command and result transfers.
// ----------------------------------------------------------------------------
module oas_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input oas_pkg::rsp_item_type rsp_item
);

   import oas_pkg::*;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   a_rsp_pulse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result without a transfer in progress");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != STATUS_OK |-> rsp_item.element_out == '0)
      else $error("error result carries an element");

   a_end_rsp : assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> $past(rsp_valid))
      else $error("busy dropped without a result");

endmodule

bind ordered_array_store oas_checker u_oas_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_item (rsp_item)
);
